### rtl/core/nta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_pkg - shared types and codes of the node table with aging
// Entry record moved along the cell chain, input kinds, event codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package nta_pkg;

    localparam int ID_W    = 32;
    localparam int TIME_W  = 32;
    localparam int EV_W    = 3;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int LIVE_W  = 5;
    localparam int CFG_IDX_W = 2;

    // input kinds
    localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SELF      = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_JOIN    = 3'd1;
    localparam logic [EV_W-1:0] EV_LEFT    = 3'd2;
    localparam logic [EV_W-1:0] EV_REFRESH = 3'd3;
    localparam logic [EV_W-1:0] EV_FULL    = 3'd4;
    localparam logic [EV_W-1:0] EV_REJECT  = 3'd5;
    localparam logic [EV_W-1:0] EV_SELF    = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd2;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd10000;

    // one table entry
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] seen;
    } entry_t;

endpackage
`default_nettype wire

### rtl/core/nta_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nta_cell - one table entry in the rotating chain
// Holds valid bit, node id and last-seen stamp; takes its neighbour's entry
// on every shift.
// ----------------------------------------------------------------------------
module nta_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire nta_pkg::entry_t d,
    output nta_pkg::entry_t      q
);

    logic                       valid_reg;
    logic [nta_pkg::ID_W-1:0]   id_reg;
    logic [nta_pkg::TIME_W-1:0] seen_reg;

    // valid bit, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= d.valid;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            id_reg   <= d.id;
            seen_reg <= d.seen;
        end
    end

    assign q.valid = valid_reg;
    assign q.id    = id_reg;
    assign q.seen  = seen_reg;

endmodule
`default_nettype wire

### rtl/core/node_table_with_aging.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// node_table_with_aging - peer membership table with aging
// Table of NUM_SLOTS entries kept in a ring of cells, scanned one entry per
// cycle at the head of the ring, unless a tick halts it for a full output.
// ----------------------------------------------------------------------------
// Usage:
//  Input beats (kind, node_id, frame_magic, frame_ok, now_ms) arrive on a
//  valid/ready channel; one beat is worked on at a time.
//  Result beats leave through an output register on a valid/ready channel;
//  last marks the final result beat of an input beat.
//  The final result beat becomes valid in the same cycle as the block
//  returns to idle and can take the next beat.
//  Rejected heartbeats and unused kinds: one result, no turn of the ring.
//  Heartbeat refresh, self register, table full and tick: one full turn of
//  the ring.
//  Heartbeat or self register that claims a new slot: a second turn to
//  write the free slot.
//  A tick gives one leave beat per removed entry, held one behind so the
//  final one can carry last; the ring halts whenever a leave beat finds the
//  output register still full, so a stalled receiver only lengthens the scan.
//  Reset empties the table at once (valid bits only); no clearing pass.
//  Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//  and are to be made only while the block is idle.
// ----------------------------------------------------------------------------
module node_table_with_aging #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [nta_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nta_pkg::ID_W-1:0]          cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [nta_pkg::KIND_W-1:0]        kind,
    input  wire logic [nta_pkg::ID_W-1:0]          node_id,
    input  wire logic [nta_pkg::ID_W-1:0]          frame_magic,
    input  wire logic                              frame_ok,
    input  wire logic [nta_pkg::TIME_W-1:0]        now_ms,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [nta_pkg::EV_W-1:0]               event_res,
    output logic [nta_pkg::ID_W-1:0]               event_node,
    output logic [nta_pkg::SLOT_W-1:0]             slot,
    output logic [nta_pkg::LIVE_W-1:0]             live_count,
    output logic                                   last
);

    localparam int IW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_SLOTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_SCAN2 = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    // configuration registers
    logic [nta_pkg::ID_W-1:0]   self_id_reg;
    logic [nta_pkg::TIME_W-1:0] timeout_reg;
    logic [nta_pkg::ID_W-1:0]   magic_reg;

    // control
    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;
    logic          free_found_reg, free_found_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    // item and scan payload
    logic [nta_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [nta_pkg::ID_W-1:0]   key_reg, key_next;
    logic [nta_pkg::TIME_W-1:0] now_reg, now_next;
    logic [IW-1:0]              hit_idx_reg, hit_idx_next;
    logic [IW-1:0]              free_idx_reg, free_idx_next;
    logic [nta_pkg::ID_W-1:0]   pend_id_reg, pend_id_next;
    logic [IW-1:0]              pend_idx_reg, pend_idx_next;
    logic [CW-1:0]              pend_count_reg, pend_count_next;
    logic [nta_pkg::EV_W-1:0]   fin_ev_reg, fin_ev_next;
    logic [nta_pkg::ID_W-1:0]   fin_node_reg, fin_node_next;
    logic [IW-1:0]              fin_idx_reg, fin_idx_next;

    // output register
    logic                         out_load;
    logic [nta_pkg::EV_W-1:0]     ev_reg, ev_next;
    logic [nta_pkg::ID_W-1:0]     node_reg, node_next;
    logic [nta_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [nta_pkg::LIVE_W-1:0]   live_reg, live_next;
    logic                         last_reg, last_next;

    // ring
    nta_pkg::entry_t cell_q [NUM_SLOTS];
    nta_pkg::entry_t head;
    nta_pkg::entry_t head_wr;
    logic            shift_en;

    // head decode
    logic                       is_lookup;
    logic                       is_tick;
    logic                       match;
    logic                       expire;
    logic [nta_pkg::TIME_W-1:0] age;
    logic                       out_free;
    logic                       in_fire;
    logic                       last_step;
    logic                       reject;

    // ------------------------------------------------------------------------
    // cell chain: each cell takes its upstream neighbour, the tail takes the
    // processed head
    // ------------------------------------------------------------------------
    generate
        for (genvar i = 0; i < NUM_SLOTS; i++)
        begin : g_cell
            nta_pkg::entry_t cell_d;
            if (i == NUM_SLOTS - 1)
            begin : g_tail
                assign cell_d = head_wr;
            end
            else
            begin : g_mid
                assign cell_d = cell_q[i + 1];
            end
            nta_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (cell_d),
                .q        (cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg <= '0;
            timeout_reg <= nta_pkg::TIMEOUT_RESET;
            magic_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nta_pkg::REG_SELF_ID: self_id_reg <= cfg_data;
                nta_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                nta_pkg::REG_MAGIC:   magic_reg   <= cfg_data;
                default:              ;
            endcase
        end
    end

    // head decode
    assign is_lookup = (kind_reg == nta_pkg::KIND_HEARTBEAT) ||
                       (kind_reg == nta_pkg::KIND_SELF);
    assign is_tick   = (kind_reg == nta_pkg::KIND_TICK);
    assign match     = head.valid && (head.id == key_reg) && !found_reg;
    assign age       = now_reg - head.seen;
    assign expire    = head.valid && (head.id != self_id_reg) && (age > timeout_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign last_step = (idx_reg == IDX_LAST);
    assign reject    = (kind == nta_pkg::KIND_HEARTBEAT) &&
                       (!frame_ok || (frame_magic != magic_reg) || (node_id == self_id_reg));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        pend_valid_next = pend_valid_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        pend_id_next    = pend_id_reg;
        pend_idx_next   = pend_idx_reg;
        pend_count_next = pend_count_reg;
        fin_ev_next     = fin_ev_reg;
        fin_node_next   = fin_node_reg;
        fin_idx_next    = fin_idx_reg;
        head_wr         = head;
        shift_en        = 1'b0;
        out_load        = 1'b0;
        ev_next         = ev_reg;
        node_next       = node_reg;
        slot_next       = slot_reg;
        live_next       = live_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next       = kind;
                    key_next        = (kind == nta_pkg::KIND_SELF) ? self_id_reg : node_id;
                    now_next        = now_ms;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (reject)
                    begin
                        fin_ev_next   = nta_pkg::EV_REJECT;
                        fin_node_next = node_id;
                        fin_idx_next  = '0;
                        state_next    = S_DONE;
                    end
                    else if ((kind == nta_pkg::KIND_HEARTBEAT) ||
                             (kind == nta_pkg::KIND_SELF) ||
                             (kind == nta_pkg::KIND_TICK))
                    begin
                        state_next = S_SCAN1;
                    end
                    else
                    begin
                        fin_ev_next   = nta_pkg::EV_NONE;
                        fin_node_next = '0;
                        fin_idx_next  = '0;
                        state_next    = S_DONE;
                    end
                end
            end

            // first turn: lookup / free search, or aging
            S_SCAN1:
            begin
                if (!(is_tick && expire && pend_valid_reg) || out_free)
                begin
                    shift_en = 1'b1;
                    idx_next = idx_reg + IW'(1);
                    if (is_lookup)
                    begin
                        if (match)
                        begin
                            head_wr.seen = now_reg;
                            found_next   = 1'b1;
                            hit_idx_next = idx_reg;
                        end
                        if (!head.valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    else if (is_tick && expire)
                    begin
                        head_wr.valid = 1'b0;
                        count_next    = count_reg - CW'(1);
                        if (pend_valid_reg)
                        begin
                            // hand the previous leave on, not the final one
                            out_load  = 1'b1;
                            ev_next   = nta_pkg::EV_LEFT;
                            node_next = pend_id_reg;
                            slot_next = nta_pkg::SLOT_W'(pend_idx_reg);
                            live_next = nta_pkg::LIVE_W'(pend_count_reg);
                            last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = head.id;
                        pend_idx_next   = idx_reg;
                        pend_count_next = count_reg - CW'(1);
                    end

                    if (last_step)
                    begin
                        idx_next = '0;
                        if (is_tick)
                        begin
                            fin_ev_next   = pend_valid_next ? nta_pkg::EV_LEFT : nta_pkg::EV_NONE;
                            fin_node_next = pend_valid_next ? pend_id_next : '0;
                            fin_idx_next  = pend_valid_next ? pend_idx_next : '0;
                            state_next    = S_DONE;
                        end
                        else if (found_next)
                        begin
                            fin_ev_next   = (kind_reg == nta_pkg::KIND_SELF) ?
                                            nta_pkg::EV_SELF : nta_pkg::EV_REFRESH;
                            fin_node_next = key_reg;
                            fin_idx_next  = hit_idx_next;
                            state_next    = S_DONE;
                        end
                        else if (free_found_next)
                        begin
                            state_next = S_SCAN2;
                        end
                        else
                        begin
                            fin_ev_next   = nta_pkg::EV_FULL;
                            fin_node_next = key_reg;
                            fin_idx_next  = '0;
                            state_next    = S_DONE;
                        end
                    end
                end
            end

            // second turn: claim the lowest free slot
            S_SCAN2:
            begin
                shift_en = 1'b1;
                idx_next = idx_reg + IW'(1);
                if (idx_reg == free_idx_reg)
                begin
                    head_wr.valid = 1'b1;
                    head_wr.id    = key_reg;
                    head_wr.seen  = now_reg;
                    count_next    = count_reg + CW'(1);
                end
                if (last_step)
                begin
                    idx_next      = '0;
                    fin_ev_next   = (kind_reg == nta_pkg::KIND_SELF) ?
                                    nta_pkg::EV_SELF : nta_pkg::EV_JOIN;
                    fin_node_next = key_reg;
                    fin_idx_next  = free_idx_reg;
                    state_next    = S_DONE;
                end
            end

            // final result beat
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    ev_next    = fin_ev_reg;
                    node_next  = fin_node_reg;
                    slot_next  = nta_pkg::SLOT_W'(fin_idx_reg);
                    live_next  = nta_pkg::LIVE_W'(count_reg);
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        pend_id_reg    <= pend_id_next;
        pend_idx_reg   <= pend_idx_next;
        pend_count_reg <= pend_count_next;
        fin_ev_reg     <= fin_ev_next;
        fin_node_reg   <= fin_node_next;
        fin_idx_reg    <= fin_idx_next;
        ev_reg         <= ev_next;
        node_reg       <= node_next;
        slot_reg       <= slot_next;
        live_reg       <= live_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = ev_reg;
    assign event_node = node_reg;
    assign slot       = slot_reg;
    assign live_count = live_reg;
    assign last       = last_reg;

endmodule
`default_nettype wire
